// ===== rtl/core/ramr_pkg.sv =====
package ramr_pkg;

  localparam int unsigned OperandBitsDef = 16;
  localparam int unsigned ResNumBits     = 32;
  localparam int unsigned ResDenBits     = 31;

  localparam logic ActSum  = 1'b0;
  localparam logic ActProd = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture operands, form products
    logic form;      // form unreduced num/den
    logic gcd_init;  // set euclid operands
    logic div_start; // start one division
    logic div_sel;   // 0: gcd remainder, 1: final quotient pair
    logic div_which; // for final: 0 numerator, 1 denominator
    logic gcd_step;  // take remainder into euclid operands
    logic qnum_take; // store numerator quotient
    logic qden_take; // store denominator quotient
    logic done;      // emit result
  } ramr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic zero_den;
    logic div_busy;
    logic gcd_zero;  // current euclid divisor is zero
  } ramr_sts_t;

endpackage

// ===== rtl/core/rational_add_mul_reduce_top.sv =====
// A request passes load, form, gcd init, the euclid remainder steps and the numerator
// and denominator divisions before the strobe; a zero denominator goes from form to done.
// Throughput: one request at a time; busy stays high until the result strobe.
// The shared one-bit-per-cycle divider takes most of the time of a request.
// Reset: asynchronous active low, returns to idle; the receiver cannot stall.
module rational_add_mul_reduce_top import ramr_pkg::*; #(
  parameter int unsigned OPERAND_BITS = OperandBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           action_i,
  input  logic signed [OPERAND_BITS-1:0] a_num_i,
  input  logic signed [OPERAND_BITS-1:0] a_den_i,
  input  logic signed [OPERAND_BITS-1:0] b_num_i,
  input  logic signed [OPERAND_BITS-1:0] b_den_i,
  output logic                           strobe,
  output logic signed [ResNumBits-1:0]   res_num_o,
  output logic signed [ResDenBits-1:0]   res_den_o,
  output logic                           zero_den_error_o
);

  ramr_cmd_t cmd;
  ramr_sts_t sts;

  ramr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  ramr_datapath #(.OperandBits(OPERAND_BITS)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .action_i         (action_i),
    .a_num_i          (a_num_i),
    .a_den_i          (a_den_i),
    .b_num_i          (b_num_i),
    .b_den_i          (b_den_i),
    .strobe_o         (strobe),
    .res_num_o        (res_num_o),
    .res_den_o        (res_den_o),
    .zero_den_error_o (zero_den_error_o)
  );

endmodule

// ===== rtl/core/ramr_div.sv =====
module ramr_div import ramr_pkg::*; #(
  parameter int unsigned W = 2 * OperandBitsDef + 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dvd_i,
  input  logic [W-1:0] dvs_i,
  output logic         busy_o,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] rem_o
);

  localparam int unsigned CntBits = $clog2(W + 1);

  logic [W-1:0]       quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [W:0]         trial;

  // Restoring division, one quotient bit per cycle while busy
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};
    if (start_i) begin
      quo_d  = dvd_i;
      rem_d  = '0;
      dvs_d  = dvs_i;
      cnt_d  = CntBits'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/ramr_datapath.sv =====
module ramr_datapath import ramr_pkg::*; #(
  parameter int unsigned OperandBits = OperandBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ramr_cmd_t                     cmd_i,
  output ramr_sts_t                     sts_o,
  input  logic                          action_i,
  input  logic signed [OperandBits-1:0] a_num_i,
  input  logic signed [OperandBits-1:0] a_den_i,
  input  logic signed [OperandBits-1:0] b_num_i,
  input  logic signed [OperandBits-1:0] b_den_i,
  output logic                          strobe_o,
  output logic signed [ResNumBits-1:0]  res_num_o,
  output logic signed [ResDenBits-1:0]  res_den_o,
  output logic                          zero_den_error_o
);

  localparam int unsigned PW = 2 * OperandBits;  // product width
  localparam int unsigned SW = PW + 1;           // sum width, also magnitudes

  logic              act_q;
  logic signed [PW-1:0] p1_q, p2_q, pd_q;       // an*bx, bn*ad, ad*bd
  logic signed [SW-1:0] num_q, den_q;
  logic              zden_q;
  logic [SW-1:0]     gn_q, gd_q;
  logic [SW-1:0]     qn_q, qd_q;
  logic              out_v_q;
  logic signed [ResNumBits-1:0] rn_q;
  logic signed [ResDenBits-1:0] rd_q;
  logic              re_q;
  logic [SW-1:0]     div_dvd, div_dvs, div_quo, div_rem;
  logic              div_busy;
  logic signed [SW-1:0] sel_val;
  logic signed [SW-1:0] qn_s, qd_s;

  function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] x);
    mag = x[SW-1] ? SW'(-x) : x;
  endfunction

  // Capture operands, form the three products, the fraction, the euclid operands and quotients
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_i;
      zden_q <= (a_den_i == '0) || (b_den_i == '0);
      p1_q   <= PW'(a_num_i) * PW'((action_i == ActProd) ? b_num_i : b_den_i);
      p2_q   <= PW'(b_num_i) * PW'(a_den_i);
      pd_q   <= PW'(a_den_i) * PW'(b_den_i);
    end
    if (cmd_i.form) begin
      num_q <= (act_q == ActProd) ? SW'(p1_q) : (SW'(p1_q) + SW'(p2_q));
      den_q <= SW'(pd_q);
    end
    if (cmd_i.gcd_init) begin
      gn_q <= mag(num_q);
      gd_q <= mag(den_q);
    end else if (cmd_i.gcd_step) begin
      gn_q <= gd_q;
      gd_q <= div_rem;
    end
    if (cmd_i.qnum_take) qn_q <= div_quo;
    if (cmd_i.qden_take) qd_q <= div_quo;
  end

  // Divider operands: euclid remainder or |value| / gcd
  assign sel_val = cmd_i.div_which ? den_q : num_q;
  assign div_dvd = cmd_i.div_sel ? mag(sel_val) : gn_q;
  assign div_dvs = cmd_i.div_sel ? gn_q : gd_q;

  ramr_div #(.W(SW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .dvd_i   (div_dvd),
    .dvs_i   (div_dvs),
    .busy_o  (div_busy),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  assign sts_o.zero_den = zden_q;
  assign sts_o.div_busy = div_busy;
  assign sts_o.gcd_zero = (gd_q == '0);

  // Restore signs of the quotients
  assign qn_s = num_q[SW-1] ? SW'(-qn_q) : qn_q;
  assign qd_s = den_q[SW-1] ? SW'(-qd_q) : qd_q;

  // Hold the result for one strobe cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else         out_v_q <= cmd_i.done;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.done) begin
      rn_q <= zden_q ? '0 : ResNumBits'(qn_s);
      rd_q <= zden_q ? '0 : ResDenBits'(qd_s);
      re_q <= zden_q;
    end
  end

  assign strobe_o         = out_v_q;
  assign res_num_o        = rn_q;
  assign res_den_o        = rd_q;
  assign zero_den_error_o = re_q;

endmodule

// ===== rtl/core/ramr_ctrl.sv =====
module ramr_ctrl import ramr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output ramr_cmd_t cmd_o,
  input  ramr_sts_t sts_i
);

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StForm  = 9'b000000010,
    StInit  = 9'b000000100,
    StGcd   = 9'b000001000,
    StGWait = 9'b000010000,
    StNum   = 9'b000100000,
    StNWait = 9'b001000000,
    StDWait = 9'b010000000,
    StDone  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: if (start_i) begin
        cmd_o.load = 1'b1;
        state_d    = StForm;
      end
      StForm: begin
        cmd_o.form = 1'b1;
        state_d    = sts_i.zero_den ? StDone : StInit;
      end
      StInit: begin
        cmd_o.gcd_init = 1'b1;
        state_d        = StGcd;
      end
      // Launch a remainder step or finish the gcd
      StGcd: begin
        if (sts_i.gcd_zero) begin
          state_d = StNum;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = StGWait;
        end
      end
      StGWait: if (!sts_i.div_busy) begin
        cmd_o.gcd_step = 1'b1;
        state_d        = StGcd;
      end
      StNum: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 1'b1;
        state_d         = StNWait;
      end
      StNWait: if (!sts_i.div_busy) begin
        cmd_o.qnum_take = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 1'b1;
        cmd_o.div_which = 1'b1;
        state_d         = StDWait;
      end
      StDWait: if (!sts_i.div_busy) begin
        cmd_o.qden_take = 1'b1;
        state_d         = StDone;
      end
      StDone: begin
        cmd_o.done = 1'b1;
        state_d    = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.gcd_step |-> !sts_i.div_busy)
    else $error("remainder taken while divider busy");
  a_done_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.done |=> state_q == StIdle)
    else $error("done not followed by idle");

endmodule

// ===== test/tb_rational_add_mul_reduce_top.sv =====
module tb_rational_add_mul_reduce_top;
  import ramr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OpBits   = OperandBitsDef;
  localparam int unsigned IdleMax  = 10000;
  localparam int unsigned NumRand  = 600;

  typedef logic signed [OpBits-1:0] opnd_t;

  typedef struct packed {
    logic                         err;
    logic signed [ResNumBits-1:0] num;
    logic signed [ResDenBits-1:0] den;
  } fraction_t;

  int unsigned n_errors;

  // Print one mismatch line and count it
  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // Predict reduced fractions and compare against the block's results
  class fraction_board;
    fraction_t pending[$];
    int unsigned n_sums, n_prods, n_zero_den, n_checked;

    function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
      longint unsigned r;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      return x;
    endfunction

    function automatic void note_request(logic act, opnd_t an, opnd_t ad, opnd_t bn, opnd_t bd);
      fraction_t f;
      longint num, den, g;
      f = '0;
      if (ad == 0 || bd == 0) begin
        f.err = 1'b1;
        n_zero_den++;
      end else begin
        if (act == ActProd) begin
          num = longint'(an) * longint'(bn);
          n_prods++;
        end else begin
          num = longint'(an) * longint'(bd) + longint'(bn) * longint'(ad);
          n_sums++;
        end
        den = longint'(ad) * longint'(bd);
        g = longint'(euclid(num < 0 ? -num : num, den < 0 ? -den : den));
        num = num / g;
        den = den / g;
        f.num = num[ResNumBits-1:0];
        f.den = den[ResDenBits-1:0];
      end
      pending.push_back(f);
    endfunction

    task check_result(fraction_t got);
      fraction_t exp_f;
      if (pending.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      exp_f = pending.pop_front();
      n_checked++;
      if (got.err !== exp_f.err)
        report($sformatf("zero_den_error %0b, want %0b", got.err, exp_f.err));
      if (got.num !== exp_f.num)
        report($sformatf("res_num %0d, want %0d", got.num, exp_f.num));
      if (got.den !== exp_f.den)
        report($sformatf("res_den %0d, want %0d", got.den, exp_f.den));
    endtask
  endclass

  logic clk, rst_n, start, busy, action, strobe, zde;
  opnd_t a_num, a_den, b_num, b_den;
  logic signed [ResNumBits-1:0] res_num;
  logic signed [ResDenBits-1:0] res_den;
  fraction_board board;
  int unsigned idle_cycles;

  rational_add_mul_reduce_top dut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy),
    .action_i(action), .a_num_i(a_num), .a_den_i(a_den), .b_num_i(b_num),
    .b_den_i(b_den), .strobe(strobe), .res_num_o(res_num), .res_den_o(res_den),
    .zero_den_error_o(zde)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Check each strobed result and watch for a stalled run
  always @(posedge clk) begin
    if (rst_n && strobe) begin
      board.check_result('{err: zde, num: res_num, den: res_den});
    end
    if (rst_n && !(strobe || (start && !busy))) begin
      idle_cycles++;
    end else begin
      idle_cycles = 0;
    end
    if (idle_cycles >= IdleMax) begin
      $display("watchdog: no progress for %0d cycles", IdleMax);
      $display("tb_rational_add_mul_reduce_top NOT OK");
      $finish;
    end
  end

  // Drive one request, wait a random gap first, hold start until busy is low
  task automatic send(logic act, opnd_t an, opnd_t ad, opnd_t bn, opnd_t bd);
    int unsigned gap;
    gap = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(posedge clk);
    start  <= 1'b1;
    action <= act;
    a_num  <= an;
    a_den  <= ad;
    b_num  <= bn;
    b_den  <= bd;
    do @(posedge clk); while (busy);
    board.note_request(act, an, ad, bn, bd);
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic opnd_t rand_opnd();
    case ($urandom_range(0, 9))
      0: return opnd_t'($urandom_range(0, 8)) - opnd_t'(4);
      1: return 16'sh8001;
      2: return 16'sh7fff;
      3: return 16'sh8000;
      4, 5: return opnd_t'($urandom_range(0, 200)) - opnd_t'(100);
      default: return opnd_t'($urandom());
    endcase
  endfunction

  function automatic opnd_t rand_den();
    opnd_t d;
    d = rand_opnd();
    if (d == 0 && $urandom_range(0, 3) != 0) d = 1;
    return d;
  endfunction

  initial begin
    logic act;
    board = new();
    n_errors = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    action = ActSum;
    a_num = '0;
    a_den = '0;
    b_num = '0;
    b_den = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, both actions, zero denominators, zero numerators
    send(ActSum,  16'sd1, 16'sd2, 16'sd1, 16'sd3);
    send(ActProd, 16'sd2, 16'sd3, 16'sd3, 16'sd4);
    send(ActSum,  16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send(ActProd, 16'sd32767, -16'sd32767, 16'sd32767, -16'sd32767);
    send(ActSum,  -16'sd32767, 16'sd1, -16'sd32767, 16'sd1);
    send(ActProd, -16'sd32767, 16'sd1, 16'sd32767, 16'sd1);
    send(ActSum,  16'sd5, 16'sd0, 16'sd1, 16'sd2);
    send(ActProd, 16'sd5, 16'sd3, 16'sd1, 16'sd0);
    send(ActSum,  16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send(ActSum,  16'sd0, -16'sd7, 16'sd0, 16'sd9);
    send(ActProd, 16'sd0, 16'sd7, 16'sd5, -16'sd9);
    send(ActSum,  16'sd1, 16'sd2, -16'sd1, 16'sd2);
    send(ActSum,  16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send(ActProd, 16'sh8000, 16'sd1, 16'sh8000, 16'sd1);
    send(ActSum,  16'sh8000, 16'sd1, 16'sh8000, 16'sd1);
    send(ActProd, 16'sd30011, 16'sd30013, 16'sd29989, 16'sd29999);
    send(ActSum,  16'sd17711, 16'sd28657, 16'sd10946, 16'sd17711);
    send(ActSum,  16'sd3, -16'sd4, 16'sd5, -16'sd6);

    // Random requests
    for (int i = 0; i < NumRand; i++) begin
      act = 1'($urandom_range(0, 1));
      send(act, rand_opnd(), rand_den(), rand_opnd(), rand_den());
    end

    // Drain outstanding results, then let the block settle
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d sums, %0d products, %0d zero-denominator requests",
             board.n_sums, board.n_prods, board.n_zero_den);
    $display("checked %0d results, %0d mismatches", board.n_checked, n_errors);
    if (n_errors == 0) begin
      $display("tb_rational_add_mul_reduce_top OK");
    end else begin
      $display("tb_rational_add_mul_reduce_top NOT OK");
    end
    $finish;
  end

endmodule
